// File: rtl/yafp_pkg.sv
`default_nettype none

package yafp_pkg;

   // Fractional bits of the fixed-point coefficients.
   localparam int COEF_FRAC_BITS = 16;

   // Coefficient magnitudes stay below 4.0, so two integer bits and a sign bit suffice.
   localparam int COEF_W = COEF_FRAC_BITS + 3;
   // Signed 9-bit sample times a signed coefficient.
   localparam int PROD_W = COEF_W + 9;
   // Width of every accumulated sum in both conversion directions.
   localparam int SUM_W  = COEF_FRAC_BITS + 14;

   localparam longint ROUND_HALF = 64'sd500000;
   localparam longint MILLION    = 64'sd1000000;

   // Six-decimal coefficients rounded half up to fixed point.
   localparam longint FIX_KY  = ((longint'(1164383) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_RV  = ((longint'(1596027) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_GU  = ((longint'(391762) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_GV  = ((longint'(812968) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_BU  = ((longint'(2017232) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_YR  = ((longint'(256788) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_YG  = ((longint'(504129) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_YB  = ((longint'(97906) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_UR  = ((longint'(148223) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_UG  = ((longint'(290993) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_UVB = ((longint'(439216) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_VG  = ((longint'(367788) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;
   localparam longint FIX_VB  = ((longint'(71427) << COEF_FRAC_BITS) + ROUND_HALF) / MILLION;

   localparam logic signed [COEF_W-1:0] K_Y   = COEF_W'(FIX_KY);
   localparam logic signed [COEF_W-1:0] K_RV  = COEF_W'(FIX_RV);
   localparam logic signed [COEF_W-1:0] K_GU  = COEF_W'(FIX_GU);
   localparam logic signed [COEF_W-1:0] K_GV  = COEF_W'(FIX_GV);
   localparam logic signed [COEF_W-1:0] K_BU  = COEF_W'(FIX_BU);
   localparam logic signed [COEF_W-1:0] K_YR  = COEF_W'(FIX_YR);
   localparam logic signed [COEF_W-1:0] K_YG  = COEF_W'(FIX_YG);
   localparam logic signed [COEF_W-1:0] K_YB  = COEF_W'(FIX_YB);
   localparam logic signed [COEF_W-1:0] K_UR  = COEF_W'(FIX_UR);
   localparam logic signed [COEF_W-1:0] K_UG  = COEF_W'(FIX_UG);
   localparam logic signed [COEF_W-1:0] K_UVB = COEF_W'(FIX_UVB);
   localparam logic signed [COEF_W-1:0] K_VG  = COEF_W'(FIX_VG);
   localparam logic signed [COEF_W-1:0] K_VB  = COEF_W'(FIX_VB);

   localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = SUM_W'(longint'(16) << COEF_FRAC_BITS);
   localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = SUM_W'(longint'(128) << COEF_FRAC_BITS);

   localparam logic [7:0] ALPHA_RESET = 8'd128;

   typedef struct packed {
      logic [7:0] y_in;
      logic [7:0] u_in;
      logic [7:0] v_in;
   } yafp_req_type;

   typedef struct packed {
      logic [7:0] y_out;
      logic [7:0] u_out;
      logic [7:0] v_out;
   } yafp_rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } yafp_rgb_type;

   // Truncate a fixed-point sum toward zero and saturate to 0..255.
   function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
      logic [7:0] v;
      if (s[SUM_W-1]) begin
         v = 8'd0;
      end else if (|s[SUM_W-2:COEF_FRAC_BITS+8]) begin
         v = 8'hFF;
      end else begin
         v = s[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/yafp_to_rgb.sv
`default_nettype none

module yafp_to_rgb (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_i,
   input  wire yafp_pkg::yafp_req_type pix_i,
   output logic                       valid_o,
   output yafp_pkg::yafp_rgb_type     rgb_o
);
   import yafp_pkg::*;

   logic                     valid1_ff, valid1_in;
   logic signed [PROD_W-1:0] ky_ff, rv_ff, gu_ff, gv_ff, bu_ff;
   logic signed [PROD_W-1:0] ky_in, rv_in, gu_in, gv_in, bu_in;
   logic signed [8:0]        y_off, u_off, v_off;

   logic                     valid2_ff, valid2_in;
   yafp_rgb_type             rgb_ff, rgb_in;
   logic signed [SUM_W-1:0]  r_sum, g_sum, b_sum;

   // Stage 1: remove the offsets and form the five products.
   always_comb begin
      y_off = $signed({1'b0, pix_i.y_in}) - 9'sd16;
      u_off = $signed({1'b0, pix_i.u_in}) - 9'sd128;
      v_off = $signed({1'b0, pix_i.v_in}) - 9'sd128;
      valid1_in = valid_i;
      ky_in = PROD_W'(K_Y) * PROD_W'(y_off);
      rv_in = PROD_W'(K_RV) * PROD_W'(v_off);
      gu_in = PROD_W'(K_GU) * PROD_W'(u_off);
      gv_in = PROD_W'(K_GV) * PROD_W'(v_off);
      bu_in = PROD_W'(K_BU) * PROD_W'(u_off);
   end

   // Stage 2: sum per channel and saturate to a byte.
   always_comb begin
      r_sum = SUM_W'(ky_ff) + SUM_W'(rv_ff);
      g_sum = SUM_W'(ky_ff) - SUM_W'(gu_ff) - SUM_W'(gv_ff);
      b_sum = SUM_W'(ky_ff) + SUM_W'(bu_ff);
      valid2_in = valid1_ff;
      rgb_in.r = to_byte(r_sum);
      rgb_in.g = to_byte(g_sum);
      rgb_in.b = to_byte(b_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
      ky_ff  <= ky_in;
      rv_ff  <= rv_in;
      gu_ff  <= gu_in;
      gv_ff  <= gv_in;
      bu_ff  <= bu_in;
      rgb_ff <= rgb_in;
   end

   assign valid_o = valid2_ff;
   assign rgb_o   = rgb_ff;

endmodule

`default_nettype wire

// File: rtl/yafp_fade.sv
`default_nettype none

module yafp_fade (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            alpha,
   input  wire logic                  valid_i,
   input  wire yafp_pkg::yafp_rgb_type rgb_i,
   output logic                       valid_o,
   output yafp_pkg::yafp_rgb_type     rgb_o
);
   import yafp_pkg::*;

   logic         valid_ff, valid_in;
   yafp_rgb_type rgb_ff, rgb_in;
   logic [15:0]  r_prod, g_prod, b_prod;

   // Each channel scales by alpha/256; the low byte of the product is dropped.
   always_comb begin
      r_prod   = 16'(rgb_i.r) * 16'(alpha);
      g_prod   = 16'(rgb_i.g) * 16'(alpha);
      b_prod   = 16'(rgb_i.b) * 16'(alpha);
      valid_in = valid_i;
      rgb_in.r = r_prod[15:8];
      rgb_in.g = g_prod[15:8];
      rgb_in.b = b_prod[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rgb_ff <= rgb_in;
   end

   assign valid_o = valid_ff;
   assign rgb_o   = rgb_ff;

endmodule

`default_nettype wire

// File: rtl/yafp_to_yuv.sv
`default_nettype none

module yafp_to_yuv (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_i,
   input  wire yafp_pkg::yafp_rgb_type rgb_i,
   output logic                       valid_o,
   output yafp_pkg::yafp_rsp_type     pix_o
);
   import yafp_pkg::*;

   logic                    valid1_ff, valid1_in;
   logic signed [SUM_W-1:0] yr_ff, yg_ff, yb_ff, ur_ff, ug_ff, ub_ff, vr_ff, vg_ff, vb_ff;
   logic signed [SUM_W-1:0] yr_in, yg_in, yb_in, ur_in, ug_in, ub_in, vr_in, vg_in, vb_in;
   logic signed [SUM_W-1:0] r_ext, g_ext, b_ext;

   logic                    valid2_ff, valid2_in;
   yafp_rsp_type            pix_ff, pix_in;
   logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

   // Stage 1: nine products of the faded channels.
   always_comb begin
      r_ext = SUM_W'($signed({1'b0, rgb_i.r}));
      g_ext = SUM_W'($signed({1'b0, rgb_i.g}));
      b_ext = SUM_W'($signed({1'b0, rgb_i.b}));
      valid1_in = valid_i;
      yr_in = SUM_W'(K_YR) * r_ext;
      yg_in = SUM_W'(K_YG) * g_ext;
      yb_in = SUM_W'(K_YB) * b_ext;
      ur_in = SUM_W'(K_UR) * r_ext;
      ug_in = SUM_W'(K_UG) * g_ext;
      ub_in = SUM_W'(K_UVB) * b_ext;
      vr_in = SUM_W'(K_UVB) * r_ext;
      vg_in = SUM_W'(K_VG) * g_ext;
      vb_in = SUM_W'(K_VB) * b_ext;
   end

   // Stage 2: add the offsets, then truncate and saturate.
   always_comb begin
      y_sum = yr_ff + yg_ff + yb_ff + LUMA_OFFSET;
      u_sum = ub_ff - ur_ff - ug_ff + CHROMA_OFFSET;
      v_sum = vr_ff - vg_ff - vb_ff + CHROMA_OFFSET;
      valid2_in = valid1_ff;
      pix_in.y_out = to_byte(y_sum);
      pix_in.u_out = to_byte(u_sum);
      pix_in.v_out = to_byte(v_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
      yr_ff  <= yr_in;
      yg_ff  <= yg_in;
      yb_ff  <= yb_in;
      ur_ff  <= ur_in;
      ug_ff  <= ug_in;
      ub_ff  <= ub_in;
      vr_ff  <= vr_in;
      vg_ff  <= vg_in;
      vb_ff  <= vb_in;
      pix_ff <= pix_in;
   end

   assign valid_o = valid2_ff;
   assign pix_o   = pix_ff;

endmodule

`default_nettype wire

// File: rtl/yuv_alpha_fade_pixel.sv
// A pixel transferred at one clock edge has its result on rsp_data, with rsp_valid high
// for one cycle, after it has passed two stages YUV to RGB, one fade stage and two
// stages RGB to YUV. Throughput: one pixel per clock cycle outside reset, fully pipelined.
// busy is high only while reset is held. The receiver cannot stall the pipeline.
// Reset is synchronous and active high: it empties the pipeline and sets alpha to 128.
`default_nettype none

module yuv_alpha_fade_pixel (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire yafp_pkg::yafp_req_type  req_data,
   output logic                        rsp_valid,
   output yafp_pkg::yafp_rsp_type      rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [7:0]             csr_wdata
);
   import yafp_pkg::*;

   logic [7:0]   alpha_ff, alpha_in;
   logic         accept;
   logic         rgb_valid, fade_valid;
   yafp_rgb_type rgb, fade_rgb;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      alpha_in = alpha_ff;
      if (csr_we) begin
         alpha_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   yafp_to_rgb u_to_rgb (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .pix_i   (req_data),
      .valid_o (rgb_valid),
      .rgb_o   (rgb)
   );

   yafp_fade u_fade (
      .clock   (clock),
      .reset   (reset),
      .alpha   (alpha_ff),
      .valid_i (rgb_valid),
      .rgb_i   (rgb),
      .valid_o (fade_valid),
      .rgb_o   (fade_rgb)
   );

   yafp_to_yuv u_to_yuv (
      .clock   (clock),
      .reset   (reset),
      .valid_i (fade_valid),
      .rgb_i   (fade_rgb),
      .valid_o (rsp_valid),
      .pix_o   (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/yafp_checker.sv
`default_nettype none

module yafp_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire yafp_pkg::yafp_rsp_type  rsp_data
);

   // Every transferred pixel produces a result strobe on rsp_valid.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("transferred pixel produced no result");

   // No result appears without a matching earlier transfer.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##5 !rsp_valid)
      else $error("result without a matching transfer");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Outside reset the block always takes a pixel.
   a_never_busy: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy outside reset");

   // A strobed result carries fully known data.
   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result data unknown");

endmodule

bind yuv_alpha_fade_pixel yafp_checker u_checker (.*);

`default_nettype wire
